// ===== rtl/uhrc_pkg.sv =====
`default_nettype none

package uhrc_pkg;

  localparam int unsigned NumPipesDefault       = 4;
  localparam int unsigned MaxPacketBytesDefault = 8;

  localparam logic [3:0] HostRetriesReset = 4'd10;

  localparam logic [7:0] PidAck   = 8'hD2;
  localparam logic [7:0] PidNak   = 8'h5A;
  localparam logic [7:0] PidNyet  = 8'h96;
  localparam logic [7:0] PidStall = 8'h1E;
  localparam logic [7:0] PidData0 = 8'hC3;
  localparam logic [7:0] PidData1 = 8'h4B;

  typedef enum logic [1:0] {
    KindStart  = 2'd0,
    KindReport = 2'd1,
    KindToggle = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OutDone    = 2'd0,
    OutTimeout = 2'd1,
    OutCorrupt = 2'd2,
    OutDevErr  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ActIssue  = 2'd0,
    ActDone   = 2'd1,
    ActFail   = 2'd2,
    ActToggle = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrCtrl   = 2'd1,
    ErrBad    = 2'd2,
    ErrDevice = 2'd3
  } error_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] pipe_index;
    logic [9:0] device_limit;
    logic       endpoint_zero;
    logic [1:0] outcome;
    logic [7:0] received_pid;
    logic [3:0] received_length;
    logic       toggle_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] result_length;
    logic [1:0] error_code;
    logic [7:0] data_pid;
  } out_word_t;

  function automatic logic [7:0] pid_of(input logic tgl);
    return tgl ? PidData1 : PidData0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/usb_handshake_retry_controller_unit.sv =====
`default_nettype none
// each word is registered in the input stage, and its result word in the output stage
// throughput: one input word per cycle while the output is not stalled, set by the
// single pass through the retry engine
// words that ask for nothing (unused kind) leave no result
// reset (async, active low): all pipe toggles to DATA0, retry counters, limit and
// active pipe to zero, host retry limit to 10, both word registers empty

module usb_handshake_retry_controller_unit #(
  parameter int unsigned NUM_PIPES        = uhrc_pkg::NumPipesDefault,
  parameter int unsigned MAX_PACKET_BYTES = uhrc_pkg::MaxPacketBytesDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [3:0]          cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  uhrc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output uhrc_pkg::out_word_t out_word_o
);

  import uhrc_pkg::*;

  logic      s1_valid;
  in_word_t  s1_word;
  logic      s2_stall;
  logic      fire;
  logic      produce;
  out_word_t res;

  assign fire = s1_valid & ~s2_stall;

  uhrc_stage #(.T(in_word_t)) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (s1_valid),
    .out_stall_i (s2_stall),
    .out_word_o  (s1_word)
  );

  uhrc_engine #(
    .NUM_PIPES        (NUM_PIPES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .word_i      (s1_word),
    .produce_o   (produce),
    .res_o       (res)
  );

  uhrc_stage #(.T(out_word_t)) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fire & produce),
    .in_stall_o  (s2_stall),
    .in_word_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/uhrc_stage.sv =====
`default_nettype none

module uhrc_stage #(
  parameter type T = logic
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  T     in_word_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output T     out_word_o
);

  logic vld_q, vld_d;
  T     word_q;

  assign in_stall_o  = vld_q & out_stall_i;
  assign vld_d       = in_stall_o ? vld_q : in_valid_i;
  assign out_valid_o = vld_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= in_word_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uhrc_engine.sv =====
`default_nettype none

module uhrc_engine #(
  parameter int unsigned NUM_PIPES        = uhrc_pkg::NumPipesDefault,
  parameter int unsigned MAX_PACKET_BYTES = uhrc_pkg::MaxPacketBytesDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [3:0]           cfg_wdata_i,
  input  wire                  fire_i,
  input  uhrc_pkg::in_word_t   word_i,
  output logic                 produce_o,
  output uhrc_pkg::out_word_t  res_o
);

  import uhrc_pkg::*;

  localparam int unsigned SlotW  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam logic [3:0]  MaxLen = 4'(MAX_PACKET_BYTES);

  function automatic logic [SlotW-1:0] slot_of(input logic [1:0] p);
    logic [4:0] v;
    v = {3'b000, p};
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(NUM_PIPES)) begin
        v = v - 5'(NUM_PIPES);
      end
    end
    return SlotW'(v);
  endfunction

  logic [NUM_PIPES-1:0] tgl_q, tgl_d;
  logic [9:0]           dev_q, dev_d;
  logic [3:0]           host_q, host_d;
  logic [9:0]           lim_q, lim_d;
  logic [1:0]           pipe_q, pipe_d;
  logic                 sa_q, sa_d;
  logic [3:0]           max_q;

  logic [SlotW-1:0] act_slot, in_slot, pid_slot;
  logic             cur_tgl;
  logic [3:0]       len_sat;
  action_e          act;
  error_e           err;
  logic [3:0]       len_out;

  assign act_slot = slot_of(pipe_q);
  assign in_slot  = slot_of(word_i.pipe_index);
  assign cur_tgl  = tgl_q[act_slot];
  assign len_sat  = (word_i.received_length > MaxLen) ? MaxLen : word_i.received_length;

  always_comb begin
    tgl_d     = tgl_q;
    dev_d     = dev_q;
    host_d    = host_q;
    lim_d     = lim_q;
    pipe_d    = pipe_q;
    sa_d      = sa_q;
    act       = ActIssue;
    err       = ErrNone;
    len_out   = 4'd0;
    pid_slot  = act_slot;
    produce_o = 1'b1;
    case (word_i.kind)
      KindStart: begin
        pipe_d   = word_i.pipe_index;
        lim_d    = word_i.device_limit;
        sa_d     = word_i.endpoint_zero;
        dev_d    = 10'd0;
        host_d   = 4'd0;
        pid_slot = in_slot;
        if (word_i.device_limit == 10'd0) begin
          act = ActFail;
          err = ErrBad;
        end else begin
          dev_d = 10'd1;
          if (max_q == 4'd0) begin
            act = ActFail;
            err = ErrBad;
          end else begin
            host_d = 4'd1;
          end
        end
      end
      KindToggle: begin
        pid_slot         = in_slot;
        tgl_d[in_slot]   = word_i.toggle_value;
        act              = ActToggle;
      end
      KindReport: begin
        case (word_i.outcome)
          OutTimeout: begin
            act = ActFail;
            err = ErrCtrl;
          end
          OutCorrupt: begin
            if (host_q >= max_q) begin
              act = ActFail;
              err = ErrBad;
            end else begin
              host_d = host_q + 4'd1;
            end
          end
          default: begin
            if (word_i.received_pid == PidAck || word_i.received_pid == pid_of(cur_tgl)) begin
              tgl_d[act_slot] = ~cur_tgl;
              if (word_i.outcome == OutDevErr) begin
                act = ActFail;
                err = ErrDevice;
              end else begin
                act     = ActDone;
                len_out = len_sat;
              end
            end else if (word_i.received_pid == PidNyet || word_i.received_pid == PidNak ||
                         word_i.received_pid == pid_of(~cur_tgl)) begin
              if (dev_q >= lim_q) begin
                act = ActFail;
                err = ErrBad;
              end else begin
                dev_d  = dev_q + 10'd1;
                host_d = 4'd0;
                if (max_q == 4'd0) begin
                  act = ActFail;
                  err = ErrBad;
                end else begin
                  host_d = 4'd1;
                end
              end
            end else if (word_i.received_pid == PidStall && sa_q) begin
              act = ActFail;
              err = ErrBad;
            end else if (word_i.outcome == OutDevErr) begin
              act = ActFail;
              err = ErrDevice;
            end else begin
              act     = ActDone;
              len_out = len_sat;
            end
          end
        endcase
      end
      default: begin
        produce_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.action        = act;
    res_o.result_length = len_out;
    res_o.error_code    = err;
    res_o.data_pid      = pid_of(tgl_d[pid_slot]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgl_q  <= '0;
      dev_q  <= 10'd0;
      host_q <= 4'd0;
      lim_q  <= 10'd0;
      pipe_q <= 2'd0;
      sa_q   <= 1'b0;
    end else if (fire_i) begin
      tgl_q  <= tgl_d;
      dev_q  <= dev_d;
      host_q <= host_d;
      lim_q  <= lim_d;
      pipe_q <= pipe_d;
      sa_q   <= sa_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= HostRetriesReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uhrc_checker.sv =====
`default_nettype none

module uhrc_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input uhrc_pkg::out_word_t out_word_o
);

  import uhrc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_err_only_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.action != ActFail |-> out_word_o.error_code == ErrNone)
    else $error("error code set without failure");

  a_fail_has_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.action == ActFail |-> out_word_o.error_code != ErrNone)
    else $error("failure without error code");

  a_len_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.action != ActDone |-> out_word_o.result_length == 4'd0)
    else $error("length reported without success");

  a_pid_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.data_pid == PidData0 || out_word_o.data_pid == PidData1)
    else $error("data pid not DATA0 or DATA1");

endmodule

bind usb_handshake_retry_controller_unit uhrc_checker u_chk (.*);

`default_nettype wire

// ===== test/tb_usb_handshake_retry_controller_unit.sv =====
`default_nettype none

module tb_usb_handshake_retry_controller_unit;
  import uhrc_pkg::*;

  localparam int QuietLimit = 2000;

  class retry_tracker;
    localparam logic [3:0] MaxLen = 4'(MaxPacketBytesDefault);

    logic [3:0] host_limit = HostRetriesReset;
    logic [3:0] toggles    = '0;
    logic [9:0] dev_tries  = '0;
    logic [9:0] dev_limit  = '0;
    logic [3:0] host_tries = '0;
    logic [1:0] cur_pipe   = '0;
    logic       stall_fail = 1'b0;
    out_word_t  pending_results[$];
    int unsigned checked    = 0;
    int unsigned mismatches = 0;

    function logic [7:0] pid_for(logic [1:0] p);
      return toggles[p] ? PidData1 : PidData0;
    endfunction

    function logic [7:0] active_pid();
      return pid_for(cur_pipe);
    endfunction

    function out_word_t result(action_e a, logic [3:0] len, error_e e, logic [1:0] p);
      out_word_t r;
      r.action        = a;
      r.result_length = len;
      r.error_code    = e;
      r.data_pid      = pid_for(p);
      return r;
    endfunction

    function out_word_t reissue();
      if (host_tries >= host_limit) return result(ActFail, 4'd0, ErrBad, cur_pipe);
      host_tries++;
      return result(ActIssue, 4'd0, ErrNone, cur_pipe);
    endfunction

    function out_word_t next_attempt();
      if (dev_tries >= dev_limit) return result(ActFail, 4'd0, ErrBad, cur_pipe);
      dev_tries++;
      host_tries = '0;
      return reissue();
    endfunction

    function out_word_t judge(in_word_t w);
      logic [7:0] cur;
      logic [7:0] other;
      logic [3:0] len;
      if (w.outcome == OutTimeout) return result(ActFail, 4'd0, ErrCtrl, cur_pipe);
      if (w.outcome == OutCorrupt) return reissue();
      len   = (w.received_length > MaxLen) ? MaxLen : w.received_length;
      cur   = active_pid();
      other = (cur == PidData0) ? PidData1 : PidData0;
      if (w.received_pid == PidAck || w.received_pid == cur) begin
        toggles[cur_pipe] = ~toggles[cur_pipe];
      end else if (w.received_pid == PidNyet || w.received_pid == PidNak ||
                   w.received_pid == other) begin
        return next_attempt();
      end else if (w.received_pid == PidStall && stall_fail) begin
        return result(ActFail, 4'd0, ErrBad, cur_pipe);
      end
      if (w.outcome == OutDevErr) return result(ActFail, 4'd0, ErrDevice, cur_pipe);
      return result(ActDone, len, ErrNone, cur_pipe);
    endfunction

    function void take_word(in_word_t w);
      case (w.kind)
        KindStart: begin
          cur_pipe   = w.pipe_index;
          dev_limit  = w.device_limit;
          stall_fail = w.endpoint_zero;
          dev_tries  = '0;
          host_tries = '0;
          pending_results.push_back(next_attempt());
        end
        KindToggle: begin
          toggles[w.pipe_index] = w.toggle_value;
          pending_results.push_back(result(ActToggle, 4'd0, ErrNone, w.pipe_index));
        end
        KindReport: pending_results.push_back(judge(w));
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got act %0d len %0d err %0d pid %h",
                 $time, got.action, got.result_length, got.error_code, got.data_pid);
        return;
      end
      exp = pending_results.pop_front();
      if (got.action !== exp.action || got.result_length !== exp.result_length ||
          got.error_code !== exp.error_code || got.data_pid !== exp.data_pid) begin
        mismatches++;
        $display("%0t: mismatch, expected act %0d len %0d err %0d pid %h,",
                 $time, exp.action, exp.result_length, exp.error_code, exp.data_pid);
        $display("  got act %0d len %0d err %0d pid %h",
                 got.action, got.result_length, got.error_code, got.data_pid);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  in_word_t   in_word_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_word_t  out_word_o;

  retry_tracker tracker;
  bit calm  = 1'b0;
  int sent  = 0;
  int quiet = 0;

  usb_handshake_retry_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(0, 99) < 17);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.take_word(in_word_i);
      if (out_valid_o && !out_stall_i) tracker.check_result(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
      else quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= QuietLimit);
    $display("timeout: no word moved for %0d cycles", QuietLimit);
    $display("[usb_handshake_retry_controller_unit] ERROR");
    $finish;
  end

  function automatic in_word_t rand_word();
    logic [31:0] r;
    r = $urandom;
    return in_word_t'(r[$bits(in_word_t)-1:0]);
  endfunction

  function automatic in_word_t mk(kind_e k, logic [1:0] p, logic [9:0] lim, logic ep,
                                  outcome_e o, logic [7:0] pid, logic [3:0] len);
    in_word_t w;
    w = '0;
    w.kind            = k;
    w.pipe_index      = p;
    w.device_limit    = lim;
    w.endpoint_zero   = ep;
    w.outcome         = o;
    w.received_pid    = pid;
    w.received_length = len;
    return w;
  endfunction

  function automatic in_word_t rand_report();
    in_word_t   w;
    logic [7:0] cur;
    int         r;
    w      = rand_word();
    w.kind = KindReport;
    cur    = tracker.active_pid();
    r      = $urandom_range(0, 99);
    if (r < 25) w.outcome = OutCorrupt;
    else if (r < 30) w.outcome = OutTimeout;
    else if (r < 42) w.outcome = OutDevErr;
    else w.outcome = OutDone;
    r = $urandom_range(0, 99);
    if (r < 18) w.received_pid = PidNak;
    else if (r < 30) w.received_pid = PidNyet;
    else if (r < 43) w.received_pid = (cur == PidData0) ? PidData1 : PidData0;
    else if (r < 62) w.received_pid = PidAck;
    else if (r < 80) w.received_pid = cur;
    else if (r < 90) w.received_pid = PidStall;
    else w.received_pid = 8'($urandom);
    w.received_length = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                                     : 4'($urandom_range(9, 15));
    return w;
  endfunction

  task automatic send(input in_word_t w);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (w.kind inside {KindStart, KindReport, KindToggle}) sent++;
    @(negedge clk_i);
  endtask

  task automatic begin_xfer(input logic [1:0] p, input logic [9:0] lim, input logic ep);
    send(mk(KindStart, p, lim, ep, OutDone, 8'h00, 4'd0));
  endtask

  task automatic report(input outcome_e o, input logic [7:0] pid, input logic [3:0] len);
    send(mk(KindReport, 2'($urandom), 10'd0, 1'b0, o, pid, len));
  endtask

  task automatic write_toggle(input logic [1:0] p, input logic v);
    in_word_t w;
    w              = mk(KindToggle, p, 10'd0, 1'b0, OutDone, 8'h00, 4'd0);
    w.toggle_value = v;
    send(w);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_host_limit(input logic [3:0] v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i            = 1'b0;
    tracker.host_limit  = v;
  endtask

  task automatic random_transaction();
    in_word_t w;
    int       r;
    if ($urandom_range(0, 99) < 5) begin
      send(rand_word());
      return;
    end
    w      = rand_word();
    w.kind = KindStart;
    r      = $urandom_range(0, 99);
    if (r < 60) w.device_limit = 10'($urandom_range(0, 4));
    else if (r < 85) w.device_limit = 10'($urandom_range(5, 20));
    else w.device_limit = 10'($urandom_range(0, 1023));
    send(w);
    if ($urandom_range(0, 9) == 0) begin
      repeat (int'(tracker.host_limit) + 1) begin
        w         = rand_word();
        w.kind    = KindReport;
        w.outcome = OutCorrupt;
        send(w);
      end
    end
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 99) < 8) begin
        w      = rand_word();
        w.kind = KindToggle;
        send(w);
      end else begin
        send(rand_report());
      end
    end
  endtask

  task automatic fill(input int target);
    while (sent < target) random_transaction();
  endtask

  task automatic directed_words();
    in_word_t junk;
    junk = '1;
    report(OutDone, PidAck, 4'd4);
    begin_xfer(2'd3, 10'd0, 1'b0);
    begin_xfer(2'd1, 10'd1023, 1'b1);
    report(OutCorrupt, 8'h00, 4'd0);
    report(OutDone, PidNak, 4'd0);
    report(OutDone, PidNyet, 4'd0);
    report(OutDone, PidData1, 4'd0);
    report(OutDone, PidData0, 4'd15);
    write_toggle(2'd2, 1'b1);
    write_toggle(2'd3, 1'b1);
    write_toggle(2'd0, 1'b0);
    begin_xfer(2'd2, 10'd5, 1'b1);
    report(OutDone, PidStall, 4'd3);
    begin_xfer(2'd2, 10'd5, 1'b0);
    report(OutDone, PidStall, 4'd8);
    begin_xfer(2'd0, 10'd3, 1'b1);
    report(OutDevErr, PidAck, 4'd2);
    begin_xfer(2'd0, 10'd3, 1'b0);
    report(OutDevErr, PidNak, 4'd0);
    report(OutDevErr, 8'hFF, 4'd0);
    begin_xfer(2'd1, 10'd1, 1'b0);
    report(OutTimeout, PidAck, 4'd0);
    begin_xfer(2'd3, 10'd1, 1'b1);
    report(OutDone, PidNyet, 4'd0);
    report(OutDone, 8'h00, 4'd0);
    send(junk);
  endtask

  initial begin
    tracker     = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_words();
    fill(260);

    settle();
    set_host_limit(4'd0);
    begin_xfer(2'd1, 10'd2, 1'b0);
    report(OutCorrupt, PidAck, 4'd0);
    fill(520);

    settle();
    set_host_limit(4'd1);
    fill(780);

    // long stretch without any idling on either side
    settle();
    set_host_limit(4'd15);
    calm = 1'b1;
    fill(1040);
    calm = 1'b0;

    settle();
    set_host_limit(4'($urandom_range(2, 14)));
    fill(1300);

    settle();
    set_host_limit(4'($urandom_range(2, 14)));
    fill(1550);

    settle();
    $display("sent %0d words, checked %0d results, %0d mismatches",
             sent, tracker.checked, tracker.mismatches);
    $display("host retry limits 10, 0, 1, 15 and two random; starts, reports, toggles, noise");
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("[usb_handshake_retry_controller_unit] OK");
    end else begin
      $display("[usb_handshake_retry_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
